// ===== sv/cccu_pkg.sv =====
// shared constants and width helpers for the circle contact unit
package cccu_pkg;

    // centre difference magnitudes are normalized so the larger lies in [2^29, 2^30)
    localparam int NORM_BITS   = 30;
    localparam int NORM_TOP    = NORM_BITS - 1;
    localparam int ROOT_W      = NORM_BITS + 1;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int QUEUE_DEPTH = 8;

    // packed width of one queued item for a given coordinate width
    function automatic int item_bits(input int cw);
        return 8 * cw + 2 * NORM_BITS + 3;
    endfunction

endpackage

// ===== sv/cccu_front.sv =====
// front end: takes a circle pair, forms the centre difference and normalizes it
module cccu_front #(
    parameter int CW = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [CW-1:0]                  i_center_a_x,
    input  logic signed [CW-1:0]                  i_center_a_y,
    input  logic        [CW-2:0]                  i_radius_a,
    input  logic signed [CW-1:0]                  i_center_b_x,
    input  logic signed [CW-1:0]                  i_center_b_y,
    input  logic        [CW-2:0]                  i_radius_b,
    input  logic [$clog2(cccu_pkg::QUEUE_DEPTH+1)-1:0] i_queue_count,
    output logic                                  o_push,
    output logic [cccu_pkg::item_bits(CW)-1:0]    o_item
);

    localparam int NB   = cccu_pkg::NORM_BITS;
    localparam int DW   = CW + 1;
    localparam int PW   = $clog2(DW);
    localparam int XW   = DW + NB;
    localparam int SW   = $clog2(XW);
    localparam int CNTW = $clog2(cccu_pkg::QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-2:0]        ra;
        logic [CW-2:0]        rb;
        logic [DW-1:0]        mx;
        logic [DW-1:0]        my;
        logic [NB-1:0]        mxn;
        logic [NB-1:0]        myn;
        logic                 sx;
        logic                 sy;
        logic                 zero;
    } t_item;

    logic          r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;
    t_item         r_f1_it, r_f2_it, r_f3_it, r_f4_it;
    t_item         n_f1_it, n_f2_it, n_f4_it;
    logic [DW-1:0] r_f1_dx, r_f1_dy, n_f1_dx, n_f1_dy;
    logic [PW-1:0] r_f3_pos, n_f3_pos;
    logic [DW-1:0] orv;
    logic          up;
    logic [SW-1:0] sh;
    logic [XW-1:0] shx, shy;
    logic [CNTW:0] load;
    logic          accept;

    // queued items plus everything still in the front must fit the queue
    assign load = (CNTW+1)'(i_queue_count) + (CNTW+1)'(r_f1_vld) + (CNTW+1)'(r_f2_vld)
                + (CNTW+1)'(r_f3_vld) + (CNTW+1)'(r_f4_vld);
    assign o_busy = load >= (CNTW+1)'(cccu_pkg::QUEUE_DEPTH);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_f1_it    = '0;
        n_f1_it.ax = i_center_a_x;
        n_f1_it.ay = i_center_a_y;
        n_f1_it.bx = i_center_b_x;
        n_f1_it.by = i_center_b_y;
        n_f1_it.ra = i_radius_a;
        n_f1_it.rb = i_radius_b;
        n_f1_dx    = {i_center_a_x[CW-1], i_center_a_x} - {i_center_b_x[CW-1], i_center_b_x};
        n_f1_dy    = {i_center_a_y[CW-1], i_center_a_y} - {i_center_b_y[CW-1], i_center_b_y};
    end

    always_comb begin
        n_f2_it      = r_f1_it;
        n_f2_it.sx   = r_f1_dx[DW-1];
        n_f2_it.sy   = r_f1_dy[DW-1];
        n_f2_it.mx   = r_f1_dx[DW-1] ? (~r_f1_dx + DW'(1)) : r_f1_dx;
        n_f2_it.my   = r_f1_dy[DW-1] ? (~r_f1_dy + DW'(1)) : r_f1_dy;
        n_f2_it.zero = (r_f1_dx == '0) && (r_f1_dy == '0);
    end

    // leading one of mx|my is the leading one of the larger magnitude
    always_comb begin
        orv      = r_f2_it.mx | r_f2_it.my;
        n_f3_pos = '0;
        for (int i = 0; i < DW; i++) begin
            if (orv[i]) begin
                n_f3_pos = PW'(i);
            end
        end
    end

    always_comb begin
        up  = r_f3_pos < PW'(cccu_pkg::NORM_TOP);
        sh  = up ? (SW'(cccu_pkg::NORM_TOP) - SW'(r_f3_pos))
                 : (SW'(r_f3_pos) - SW'(cccu_pkg::NORM_TOP));
        shx = up ? (XW'(r_f3_it.mx) << sh) : (XW'(r_f3_it.mx) >> sh);
        shy = up ? (XW'(r_f3_it.my) << sh) : (XW'(r_f3_it.my) >> sh);
        n_f4_it     = r_f3_it;
        n_f4_it.mxn = shx[NB-1:0];
        n_f4_it.myn = shy[NB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
        end else begin
            r_f1_vld <= accept;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_it  <= n_f1_it;
        r_f1_dx  <= n_f1_dx;
        r_f1_dy  <= n_f1_dy;
        r_f2_it  <= n_f2_it;
        r_f3_it  <= r_f2_it;
        r_f3_pos <= n_f3_pos;
        r_f4_it  <= n_f4_it;
    end

    assign o_push = r_f4_vld;
    assign o_item = r_f4_it;

endmodule

// ===== sv/cccu_queue.sv =====
// small queue between the front end and the back end
module cccu_queue #(
    parameter int W = 327
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  logic [W-1:0]                               i_data,
    output logic [$clog2(cccu_pkg::QUEUE_DEPTH+1)-1:0] o_count,
    output logic                                       o_vld,
    output logic [W-1:0]                               o_data
);

    localparam int DEPTH = cccu_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_count;
    logic            r_vld;
    logic [W-1:0]    r_data;
    logic            pop;

    // the back end never stalls, so the head leaves as soon as it is there
    assign pop = r_count != '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_data;
        end
        if (pop) begin
            r_data <= mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= pop;
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + CNTW'(i_push) - CNTW'(pop);
        end
    end

    assign o_count = r_count;
    assign o_vld   = r_vld;
    assign o_data  = r_data;

endmodule

// ===== sv/cccu_back.sv =====
// back end: overlap test, pipelined square root and divide, rim points
module cccu_back #(
    parameter int CW = 32,
    parameter int NW = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic [cccu_pkg::item_bits(CW)-1:0] i_item,
    output logic                               o_strobe,
    output logic signed [NW-1:0]               o_normal_x,
    output logic signed [NW-1:0]               o_normal_y,
    output logic signed [NW-1:0]               o_tangent_x,
    output logic signed [NW-1:0]               o_tangent_y,
    output logic                               o_contact_count,
    output logic signed [CW-1:0]               o_contact_a_x,
    output logic signed [CW-1:0]               o_contact_a_y,
    output logic signed [CW-1:0]               o_contact_b_x,
    output logic signed [CW-1:0]               o_contact_b_y
);

    localparam int NB   = cccu_pkg::NORM_BITS;
    localparam int DW   = CW + 1;
    localparam int PNW  = 2 * NB;
    localparam int PDW  = 2 * DW;
    localparam int PRW  = 2 * CW;
    localparam int RTW  = cccu_pkg::ROOT_W;
    localparam int SRW  = RTW + 2;
    localparam int XSW  = 2 * RTW;
    localparam int SQ   = cccu_pkg::SQRT_STEPS;
    localparam int DS   = NW + 1;
    localparam int K    = NW - 1;
    localparam int PMW  = NW + CW - 2;
    localparam int EW   = CW + 2;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-2:0]        ra;
        logic [CW-2:0]        rb;
        logic [DW-1:0]        mx;
        logic [DW-1:0]        my;
        logic [NB-1:0]        mxn;
        logic [NB-1:0]        myn;
        logic                 sx;
        logic                 sy;
        logic                 zero;
    } t_item;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-2:0]        ra;
        logic [CW-2:0]        rb;
        logic [NB-1:0]        mxn;
        logic [NB-1:0]        myn;
        logic                 sx;
        logic                 sy;
        logic                 zero;
        logic                 hit;
    } t_side;

    t_item          it;
    logic           r_b1_vld, r_b2_vld;
    t_item          r_b1_it, r_b2_it;
    logic [PNW-1:0] r_b1_nx2, r_b1_ny2;
    logic [PDW-1:0] r_b1_dx2, r_b1_dy2;
    logic [CW-1:0]  r_b1_rs;
    logic [PNW:0]   r_b2_s;
    logic [PDW:0]   r_b2_d2;
    logic [PRW-1:0] r_b2_rs2;
    t_side          n_sq0_sd;

    logic           r_sq_vld  [SQ+1];
    logic [SRW-1:0] r_sq_rem  [SQ+1];
    logic [RTW-1:0] r_sq_root [SQ+1];
    logic [XSW-1:0] r_sq_x    [SQ+1];
    t_side          r_sq_sd   [SQ+1];

    logic           r_dv_vld [DS+1];
    logic [RTW-1:0] r_dv_rx  [DS+1];
    logic [RTW-1:0] r_dv_ry  [DS+1];
    logic [RTW-1:0] r_dv_r   [DS+1];
    logic [DS-1:0]  r_dv_qx  [DS+1];
    logic [DS-1:0]  r_dv_qy  [DS+1];
    t_side          r_dv_sd  [DS+1];

    logic           r_r1_vld, r_r2_vld;
    logic [NW-2:0]  r_r1_qx, r_r1_qy, n_r1_qx, n_r1_qy;
    t_side          r_r1_sd, r_r2_sd;
    logic [DS:0]    sum_x, sum_y;
    logic [PMW-1:0] r_r2_pax, r_r2_pay, r_r2_pbx, r_r2_pby;
    logic [NW-1:0]  r_r2_nx, r_r2_ny;

    logic [CW-1:0]  m_ax, m_ay, m_bx, m_by;
    logic [CW-1:0]  n_cax, n_cay, n_cbx, n_cby;
    logic           r_strobe, r_count;
    logic [NW-1:0]  r_nx, r_ny, r_tx, r_ty;
    logic [CW-1:0]  r_cax, r_cay, r_cbx, r_cby;

    assign it = i_item;

    // round half up on the rim offset magnitude
    function automatic logic [CW-1:0] rim_mag(input logic [PMW-1:0] p);
        logic [PMW:0] s;
        s = (PMW+1)'(p) + ((PMW+1)'(1) << (K - 1));
        return s[PMW:K];
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic signed [CW-1:0] c,
                                              input logic [CW-1:0] m, input logic neg);
        logic [EW-1:0] v;
        v = neg ? ({{2{c[CW-1]}}, c} - {2'b00, m}) : ({{2{c[CW-1]}}, c} + {2'b00, m});
        if (v[EW-1:CW-1] == '0 || v[EW-1:CW-1] == '1) begin
            return v[CW-1:0];
        end else if (v[EW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // squares and radius sum
    always_ff @(posedge i_clk) begin
        r_b1_it  <= it;
        r_b1_nx2 <= PNW'(it.mxn) * PNW'(it.mxn);
        r_b1_ny2 <= PNW'(it.myn) * PNW'(it.myn);
        r_b1_dx2 <= PDW'(it.mx) * PDW'(it.mx);
        r_b1_dy2 <= PDW'(it.my) * PDW'(it.my);
        r_b1_rs  <= CW'(it.ra) + CW'(it.rb);
        r_b2_it  <= r_b1_it;
        r_b2_s   <= (PNW+1)'(r_b1_nx2) + (PNW+1)'(r_b1_ny2);
        r_b2_d2  <= (PDW+1)'(r_b1_dx2) + (PDW+1)'(r_b1_dy2);
        r_b2_rs2 <= PRW'(r_b1_rs) * PRW'(r_b1_rs);
    end

    always_comb begin
        n_sq0_sd      = '0;
        n_sq0_sd.ax   = r_b2_it.ax;
        n_sq0_sd.ay   = r_b2_it.ay;
        n_sq0_sd.bx   = r_b2_it.bx;
        n_sq0_sd.by   = r_b2_it.by;
        n_sq0_sd.ra   = r_b2_it.ra;
        n_sq0_sd.rb   = r_b2_it.rb;
        n_sq0_sd.mxn  = r_b2_it.mxn;
        n_sq0_sd.myn  = r_b2_it.myn;
        n_sq0_sd.sx   = r_b2_it.sx;
        n_sq0_sd.sy   = r_b2_it.sy;
        n_sq0_sd.zero = r_b2_it.zero;
        n_sq0_sd.hit  = r_b2_d2 < (PDW+1)'(r_b2_rs2);
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_x[0]    <= XSW'(r_b2_s);
        r_sq_sd[0]   <= n_sq0_sd;
    end

    // one root bit per stage
    for (genvar k = 1; k <= SQ; k++) begin : g_sq
        logic [SRW+1:0] rem2, trial;
        logic           ge;
        always_comb begin
            rem2  = {r_sq_rem[k-1], r_sq_x[k-1][XSW-1 -: 2]};
            trial = (SRW+2)'({r_sq_root[k-1], 2'b01});
            ge    = rem2 >= trial;
        end
        always_ff @(posedge i_clk) begin
            r_sq_rem[k]  <= ge ? SRW'(rem2 - trial) : SRW'(rem2);
            r_sq_root[k] <= {r_sq_root[k-1][RTW-2:0], ge};
            r_sq_x[k]    <= r_sq_x[k-1] << 2;
            r_sq_sd[k]   <= r_sq_sd[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rx[0] <= RTW'(r_sq_sd[SQ].mxn);
        r_dv_ry[0] <= RTW'(r_sq_sd[SQ].myn);
        r_dv_r[0]  <= r_sq_root[SQ];
        r_dv_qx[0] <= '0;
        r_dv_qy[0] <= '0;
        r_dv_sd[0] <= r_sq_sd[SQ];
    end

    // one quotient bit per stage, both axes side by side
    for (genvar j = 1; j <= DS; j++) begin : g_dv
        logic [RTW:0] tx, ty, dr;
        logic         bx, by;
        always_comb begin
            dr = {1'b0, r_dv_r[j-1]};
            if (j == 1) begin
                tx = {1'b0, r_dv_rx[j-1]};
                ty = {1'b0, r_dv_ry[j-1]};
            end else begin
                tx = {r_dv_rx[j-1], 1'b0};
                ty = {r_dv_ry[j-1], 1'b0};
            end
            bx = tx >= dr;
            by = ty >= dr;
        end
        always_ff @(posedge i_clk) begin
            r_dv_rx[j] <= bx ? RTW'(tx - dr) : RTW'(tx);
            r_dv_ry[j] <= by ? RTW'(ty - dr) : RTW'(ty);
            r_dv_r[j]  <= r_dv_r[j-1];
            r_dv_qx[j] <= {r_dv_qx[j-1][DS-2:0], bx};
            r_dv_qy[j] <= {r_dv_qy[j-1][DS-2:0], by};
            r_dv_sd[j] <= r_dv_sd[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end
    end

    // round half up, then clamp below one
    always_comb begin
        sum_x = (DS+1)'(r_dv_qx[DS]) + (DS+1)'(1);
        sum_y = (DS+1)'(r_dv_qy[DS]) + (DS+1)'(1);
        n_r1_qx = (sum_x[DS:1] > DS'({(NW-1){1'b1}})) ? {(NW-1){1'b1}} : sum_x[NW-1:1];
        n_r1_qy = (sum_y[DS:1] > DS'({(NW-1){1'b1}})) ? {(NW-1){1'b1}} : sum_y[NW-1:1];
    end

    always_ff @(posedge i_clk) begin
        r_r1_qx  <= n_r1_qx;
        r_r1_qy  <= n_r1_qy;
        r_r1_sd  <= r_dv_sd[DS];
        r_r2_sd  <= r_r1_sd;
        r_r2_pax <= PMW'(r_r1_qx) * PMW'(r_r1_sd.ra);
        r_r2_pay <= PMW'(r_r1_qy) * PMW'(r_r1_sd.ra);
        r_r2_pbx <= PMW'(r_r1_qx) * PMW'(r_r1_sd.rb);
        r_r2_pby <= PMW'(r_r1_qy) * PMW'(r_r1_sd.rb);
        r_r2_nx  <= r_r1_sd.sx ? (NW'(0) - NW'(r_r1_qx)) : NW'(r_r1_qx);
        r_r2_ny  <= r_r1_sd.sy ? (NW'(0) - NW'(r_r1_qy)) : NW'(r_r1_qy);
    end

    // a moves against the normal, b along it
    always_comb begin
        m_ax  = rim_mag(r_r2_pax);
        m_ay  = rim_mag(r_r2_pay);
        m_bx  = rim_mag(r_r2_pbx);
        m_by  = rim_mag(r_r2_pby);
        n_cax = sat_add(r_r2_sd.ax, m_ax, !r_r2_sd.sx);
        n_cay = sat_add(r_r2_sd.ay, m_ay, !r_r2_sd.sy);
        n_cbx = sat_add(r_r2_sd.bx, m_bx, r_r2_sd.sx);
        n_cby = sat_add(r_r2_sd.by, m_by, r_r2_sd.sy);
    end

    always_ff @(posedge i_clk) begin
        if (r_r2_sd.zero) begin
            r_nx <= '0;
            r_ny <= '0;
            r_tx <= '0;
            r_ty <= '0;
        end else begin
            r_nx <= r_r2_nx;
            r_ny <= r_r2_ny;
            r_tx <= NW'(0) - r_r2_ny;
            r_ty <= r_r2_nx;
        end
        if (r_r2_sd.zero || !r_r2_sd.hit) begin
            r_count <= 1'b0;
            r_cax   <= '0;
            r_cay   <= '0;
            r_cbx   <= '0;
            r_cby   <= '0;
        end else begin
            r_count <= 1'b1;
            r_cax   <= n_cax;
            r_cay   <= n_cay;
            r_cbx   <= n_cbx;
            r_cby   <= n_cby;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld    <= 1'b0;
            r_b2_vld    <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_r1_vld    <= 1'b0;
            r_r2_vld    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_b1_vld    <= i_vld;
            r_b2_vld    <= r_b1_vld;
            r_sq_vld[0] <= r_b2_vld;
            r_dv_vld[0] <= r_sq_vld[SQ];
            r_r1_vld    <= r_dv_vld[DS];
            r_r2_vld    <= r_r1_vld;
            r_strobe    <= r_r2_vld;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_normal_x      = r_nx;
    assign o_normal_y      = r_ny;
    assign o_tangent_x     = r_tx;
    assign o_tangent_y     = r_ty;
    assign o_contact_count = r_count;
    assign o_contact_a_x   = r_cax;
    assign o_contact_a_y   = r_cay;
    assign o_contact_b_x   = r_cbx;
    assign o_contact_b_y   = r_cby;

endmodule

// ===== sv/circle_circle_contact_unit.sv =====
// top level of the circle-circle contact unit
// Takes one circle pair per clock when start is high and busy is low, and gives one
// contact result per pair, in order, marked by o_strobe for one cycle; the result must
// be taken that cycle. From the accepting edge to its strobe a pair passes through
// four front stages that normalize the centre difference, a short queue that follows,
// then a 31-stage square root and a NORMAL_WIDTH+1 stage divider, which set most of the depth.
// Every stage holds one pair, so one pair per clock is sustained and busy stays low in
// steady flow; it only guards the queue.
module circle_circle_contact_unit #(
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_center_a_x,
    input  logic signed [COORD_WIDTH-1:0]  i_center_a_y,
    input  logic        [COORD_WIDTH-2:0]  i_radius_a,
    input  logic signed [COORD_WIDTH-1:0]  i_center_b_x,
    input  logic signed [COORD_WIDTH-1:0]  i_center_b_y,
    input  logic        [COORD_WIDTH-2:0]  i_radius_b,
    output logic                           o_strobe,
    output logic signed [NORMAL_WIDTH-1:0] o_normal_x,
    output logic signed [NORMAL_WIDTH-1:0] o_normal_y,
    output logic signed [NORMAL_WIDTH-1:0] o_tangent_x,
    output logic signed [NORMAL_WIDTH-1:0] o_tangent_y,
    output logic                           o_contact_count,
    output logic signed [COORD_WIDTH-1:0]  o_contact_a_x,
    output logic signed [COORD_WIDTH-1:0]  o_contact_a_y,
    output logic signed [COORD_WIDTH-1:0]  o_contact_b_x,
    output logic signed [COORD_WIDTH-1:0]  o_contact_b_y
);

    localparam int IW   = cccu_pkg::item_bits(COORD_WIDTH);
    localparam int CNTW = $clog2(cccu_pkg::QUEUE_DEPTH + 1);

    logic [CNTW-1:0] q_count;
    logic            push, q_vld;
    logic [IW-1:0]   item, q_data;

    cccu_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_center_a_x  (i_center_a_x),
        .i_center_a_y  (i_center_a_y),
        .i_radius_a    (i_radius_a),
        .i_center_b_x  (i_center_b_x),
        .i_center_b_y  (i_center_b_y),
        .i_radius_b    (i_radius_b),
        .i_queue_count (q_count),
        .o_push        (push),
        .o_item        (item)
    );

    cccu_queue #(.W(IW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_count (q_count),
        .o_vld   (q_vld),
        .o_data  (q_data)
    );

    cccu_back #(.CW(COORD_WIDTH), .NW(NORMAL_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (q_vld),
        .i_item          (q_data),
        .o_strobe        (o_strobe),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_tangent_x     (o_tangent_x),
        .o_tangent_y     (o_tangent_y),
        .o_contact_count (o_contact_count),
        .o_contact_a_x   (o_contact_a_x),
        .o_contact_a_y   (o_contact_a_y),
        .o_contact_b_x   (o_contact_b_x),
        .o_contact_b_y   (o_contact_b_y)
    );

`ifndef SYNTHESIS
    // the back end drains one beat per cycle, so the queue never backs up
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised in steady flow");

    a_contact_has_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_contact_count |-> (o_normal_x != '0 || o_normal_y != '0))
        else $error("contact reported with zero normal");

    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_contact_count |->
            (o_contact_a_x == '0 && o_contact_a_y == '0 &&
             o_contact_b_x == '0 && o_contact_b_y == '0))
        else $error("contact points set without contact");

    a_tangent_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_tangent_y == o_normal_x && o_tangent_x == -o_normal_y))
        else $error("tangent is not the turned normal");
`endif

endmodule

// ===== dv/tb_circle_circle_contact_unit.sv =====
// self-checking testbench for the circle-circle contact unit
module tb_circle_circle_contact_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int NW = 16;
    localparam int N_RANDOM = 600;
    localparam int TAIL_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] ax, ay;
        logic        [CW-2:0] ra;
        logic signed [CW-1:0] bx, by;
        logic        [CW-2:0] rb;
    } t_circle_pair;

    typedef struct {
        logic signed [NW-1:0] nx, ny, tx, ty;
        logic                 hit;
        logic signed [CW-1:0] cax, cay, cbx, cby;
    } t_manifold;

    typedef struct {
        t_circle_pair pair;
        bit           typed;
        t_manifold    want;
    } t_pair_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] i_center_a_x = '0, i_center_a_y = '0;
    logic        [CW-2:0] i_radius_a = '0;
    logic signed [CW-1:0] i_center_b_x = '0, i_center_b_y = '0;
    logic        [CW-2:0] i_radius_b = '0;
    logic                 o_strobe;
    logic signed [NW-1:0] o_normal_x, o_normal_y, o_tangent_x, o_tangent_y;
    logic                 o_contact_count;
    logic signed [CW-1:0] o_contact_a_x, o_contact_a_y, o_contact_b_x, o_contact_b_y;

    t_manifold pending_manifolds[$];
    int        mismatch_count = 0;
    int        beats_sent = 0;
    int        beats_checked = 0;
    int        contacts_seen = 0;
    longint    cycle_count = 0;

    circle_circle_contact_unit #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint rim_offset(longint n, longint unsigned radius);
        longint unsigned m;
        m = ((n < 0 ? -n : n) * radius + (64'd1 << (NW - 2))) >> (NW - 1);
        return n < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[CW-1:0];
    endfunction

    function automatic t_manifold contact_manifold(t_circle_pair p);
        t_manifold m;
        longint ax, ay, bx, by, dx, dy, nx, ny, tneg;
        longint unsigned mx, my, big, r, qx, qy, ra, rb, rs;
        logic [127:0] dist2, reach2;
        m = '{default: '0};
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        ra = p.ra; rb = p.rb;
        dx = ax - bx; dy = ay - by;
        if (dx == 0 && dy == 0) return m;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        dist2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        big = mx > my ? mx : my;
        while (big >= (64'd1 << 30)) begin
            big >>= 1; mx >>= 1; my >>= 1;
        end
        while (big < (64'd1 << 29)) begin
            big <<= 1; mx <<= 1; my <<= 1;
        end
        r = int_sqrt(mx * mx + my * my);
        qx = (((mx << NW) / r) + 1) >> 1;
        qy = (((my << NW) / r) + 1) >> 1;
        if (qx > (64'd1 << (NW - 1)) - 1) qx = (64'd1 << (NW - 1)) - 1;
        if (qy > (64'd1 << (NW - 1)) - 1) qy = (64'd1 << (NW - 1)) - 1;
        nx = dx < 0 ? -longint'(qx) : longint'(qx);
        ny = dy < 0 ? -longint'(qy) : longint'(qy);
        tneg = -ny;
        m.nx = nx[NW-1:0];
        m.ny = ny[NW-1:0];
        m.tx = tneg[NW-1:0];
        m.ty = nx[NW-1:0];
        rs = ra + rb;
        reach2 = 128'(rs) * 128'(rs);
        if (dist2 < reach2) begin
            m.hit = 1'b1;
            m.cax = clamp_coord(ax - rim_offset(nx, ra));
            m.cay = clamp_coord(ay - rim_offset(ny, ra));
            m.cbx = clamp_coord(bx + rim_offset(nx, rb));
            m.cby = clamp_coord(by + rim_offset(ny, rb));
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on beat %0d: %s got %0d expected %0d",
                 $time, beats_checked, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_manifold w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_manifolds.size() == 0) begin
                $display("[%0t] result beat with nothing outstanding", $time);
                mismatch_count++;
            end else begin
                w = pending_manifolds.pop_front();
                if (o_normal_x !== w.nx) report_mismatch("normal_x", o_normal_x, w.nx);
                if (o_normal_y !== w.ny) report_mismatch("normal_y", o_normal_y, w.ny);
                if (o_tangent_x !== w.tx) report_mismatch("tangent_x", o_tangent_x, w.tx);
                if (o_tangent_y !== w.ty) report_mismatch("tangent_y", o_tangent_y, w.ty);
                if (o_contact_count !== w.hit)
                    report_mismatch("contact_count", o_contact_count, w.hit);
                if (o_contact_a_x !== w.cax)
                    report_mismatch("contact_a_x", o_contact_a_x, w.cax);
                if (o_contact_a_y !== w.cay)
                    report_mismatch("contact_a_y", o_contact_a_y, w.cay);
                if (o_contact_b_x !== w.cbx)
                    report_mismatch("contact_b_x", o_contact_b_x, w.cbx);
                if (o_contact_b_y !== w.cby)
                    report_mismatch("contact_b_y", o_contact_b_y, w.cby);
                if (w.hit) contacts_seen++;
                beats_checked++;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** circle_circle_contact_unit: FAILED **");
            $finish;
        end
    end

    // drives one pair and holds it until the edge that accepts it
    task automatic send_pair(t_circle_pair p, t_manifold want, bit allow_gap);
        int gap;
        i_center_a_x <= p.ax; i_center_a_y <= p.ay; i_radius_a <= p.ra;
        i_center_b_x <= p.bx; i_center_b_y <= p.by; i_radius_b <= p.rb;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_manifolds.push_back(want);
        beats_sent++;
        if (allow_gap && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_circle_pair random_pair();
        t_circle_pair p;
        int unsigned spread;
        p.ax = $urandom; p.ay = $urandom;
        p.ra = (CW-1)'($urandom); p.rb = (CW-1)'($urandom);
        p.bx = $urandom; p.by = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: begin
                p.bx = p.ax; p.by = p.ay;
            end
            default: begin
                // nearby circles with modest radii so overlap and no-overlap both occur
                spread = 1 << $urandom_range(1, 24);
                p.bx = p.ax + $signed($urandom_range(0, 2 * spread)) - $signed(spread);
                p.by = p.ay + $signed($urandom_range(0, 2 * spread)) - $signed(spread);
                p.ra = (CW-1)'($urandom_range(0, spread));
                p.rb = (CW-1)'($urandom_range(0, spread));
                if ($urandom_range(0, 3) == 0) p.by = p.ay;
                if ($urandom_range(0, 3) == 0) p.bx = p.ax;
            end
        endcase
        return p;
    endfunction

    t_pair_row directed_rows[$];

    function automatic t_pair_row mk_row(longint ax, longint ay, longint ra,
                                         longint bx, longint by, longint rb);
        t_pair_row row;
        row.pair = '{ax[CW-1:0], ay[CW-1:0], ra[CW-2:0], bx[CW-1:0], by[CW-1:0], rb[CW-2:0]};
        row.typed = 1'b0;
        row.want = '{default: '0};
        return row;
    endfunction

    initial begin
        t_pair_row row;
        t_manifold w;
        // coincident centres: everything zero
        row = mk_row(0, 0, 0, 0, 0, 0);
        row.typed = 1; directed_rows.push_back(row);
        row = mk_row(32'h7fffffff, -32'sh80000000, 31'h7fffffff,
                     32'h7fffffff, -32'sh80000000, 31'h7fffffff);
        row.typed = 1; directed_rows.push_back(row);
        // just touching along x: normal saturates, no contact
        row = mk_row(2, 0, 1, 0, 0, 1);
        row.typed = 1; row.want.nx = 16'sh7fff; row.want.ty = 16'sh7fff;
        directed_rows.push_back(row);
        // apart along -y
        row = mk_row(0, -10, 1, 0, 10, 1);
        row.typed = 1; row.want.ny = -16'sh7fff; row.want.tx = 16'sh7fff;
        directed_rows.push_back(row);
        directed_rows.push_back(mk_row(1, 0, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(3, 4, 3, 0, 0, 3));
        directed_rows.push_back(mk_row(-3, -4, 65536, 0, 0, 65536));
        directed_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                                       -32'sh80000000, -32'sh80000000, 31'h7fffffff));
        directed_rows.push_back(mk_row(-32'sh80000000, 0, 31'h7fffffff,
                                       32'h7fffffff, 0, 31'h7fffffff));
        directed_rows.push_back(mk_row(32'h7ffffff0, 5, 31'h7fffffff, 32'h7fffffe0, 0, 0));
        directed_rows.push_back(mk_row(-32'sh7ffffff0, -5, 31'h7fffffff,
                                       -32'sh7fffffe0, 0, 31'h7fffffff));
        directed_rows.push_back(mk_row(1, 1, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(1, -1, 100, 0, 0, 100));
        directed_rows.push_back(mk_row(-1, 2, 0, 0, 0, 5));
        directed_rows.push_back(mk_row(0, 1 << 20, 1 << 19, 0, 0, 1 << 19));
        directed_rows.push_back(mk_row(7, 1 << 29, 1 << 30, 0, 0, 0));
        directed_rows.push_back(mk_row(12345678, -87654321, 31'h40000000, -5, 9, 31'h1234567));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            w = directed_rows[k].typed ? directed_rows[k].want
                                       : contact_manifold(directed_rows[k].pair);
            send_pair(directed_rows[k].pair, w, 1'b1);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            t_circle_pair p;
            if (n == N_RANDOM / 2) begin
                // let the pipeline drain completely before resuming
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_manifolds.size() != 0) @(posedge i_clk);
            end
            p = random_pair();
            send_pair(p, contact_manifold(p), n < N_RANDOM - 100);
        end
        start <= 1'b0;

        while (pending_manifolds.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d circle pairs, checked %0d results, %0d with contact",
                 beats_sent, beats_checked, contacts_seen);
        $display("covered coincident, touching, extreme and random pairs");
        if (mismatch_count == 0)
            $display("** circle_circle_contact_unit: PASSED **");
        else
            $display("** circle_circle_contact_unit: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/cccu_pkg.sv
sv/cccu_front.sv
sv/cccu_queue.sv
sv/cccu_back.sv
sv/circle_circle_contact_unit.sv
dv/tb_circle_circle_contact_unit.sv
